>>> rtl/sxfb_pkg.sv
// sxfb_pkg: operation codes and controller command type for the sprite xor
// frame buffer. No dependencies.
package sxfb_pkg;

  localparam logic [1:0] OP_DRAW  = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_WRITE = 2'd3;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

endpackage

>>> rtl/sxfb_ram.sv
// sxfb_ram: generic single write port, single read port ram with a
// registered read. No dependencies.
module sxfb_ram #(
  parameter int DW    = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/sxfb_ctrl.sv
// sxfb_ctrl: two-state controller, accept then execute, with busy and the
// result strobe. Depends on sxfb_pkg.
module sxfb_ctrl
  import sxfb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  output logic      done,
  output ctrl_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;

  assign cmd.load = start && !busy;
  assign cmd.exec = (state == S_EXEC);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          done <= 1'b0;
          if (start) begin
            state <= S_EXEC;
            busy  <= 1'b1;
          end
        end
        S_EXEC: begin
          state <= S_IDLE;
          busy  <= 1'b0;
          done  <= 1'b1;
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
          done  <= 1'b0;
        end
      endcase
    end
  end

endmodule

>>> rtl/sxfb_datapath.sv
// sxfb_datapath: coordinate wrap, sprite row mask, row valid bits, collision
// accumulator and result registers. Depends on sxfb_pkg; drives sxfb_ram.
module sxfb_datapath
  import sxfb_pkg::*;
#(
  parameter int WIDTH  = 64,
  parameter int HEIGHT = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  ctrl_cmd_t                 cmd,
  input  logic [1:0]                op,
  input  logic [5:0]                x,
  input  logic [4:0]                y,
  input  logic [7:0]                sprite_row,
  input  logic [4:0]                row_offset,
  input  logic                      last_row,
  input  logic                      pixel_in,
  output logic [$clog2(HEIGHT)-1:0] ram_raddr,
  input  logic [WIDTH-1:0]          ram_rdata,
  output logic                      ram_we,
  output logic [$clog2(HEIGHT)-1:0] ram_waddr,
  output logic [WIDTH-1:0]          ram_wdata,
  output logic                      pixel_out,
  output logic                      collision,
  output logic                      sprite_done
);

  localparam int CW = $clog2(WIDTH);
  localparam int RW = $clog2(HEIGHT);
  localparam logic [6:0] W7 = 7'(WIDTH);
  localparam logic [6:0] H7 = 7'(HEIGHT);

  // reduce a value below 64 by a modulus of at least 8
  function automatic logic [6:0] wrap(input logic [6:0] v, input logic [6:0] m);
    logic [6:0] r;
    r = v;
    for (int i = 0; i < 8; i++) begin
      if (r >= m) begin
        r = r - m;
      end
    end
    return r;
  endfunction

  logic [1:0]       op_q;
  logic [RW-1:0]    row_q;
  logic [CW-1:0]    col_q;
  logic [WIDTH-1:0] flip_q;
  logic             first_q;
  logic             last_q;
  logic             pin_q;
  logic             coll_acc;
  logic             coll_next;
  logic [HEIGHT-1:0] row_valid;

  logic [6:0]       xm;
  logic [6:0]       ym;
  logic [6:0]       rm;
  logic [6:0]       rs;
  logic [6:0]       cs;
  logic [WIDTH-1:0] flip;
  logic [RW-1:0]    row_sel;
  logic [WIDTH-1:0] row_eff;
  logic [WIDTH-1:0] pix_row;
  logic             hit;

  always_comb begin
    xm = wrap({1'b0, x}, W7);
    ym = wrap({2'b00, y}, H7);
    rm = wrap({2'b00, row_offset}, H7);
    rs = ym + rm;
    if (rs >= H7) begin
      rs = rs - H7;
    end
    row_sel = (op == OP_DRAW) ? rs[RW-1:0] : ym[RW-1:0];
    flip = '0;
    for (int b = 0; b < 8; b++) begin
      cs = xm + 7'(b);
      if (cs >= W7) begin
        cs = cs - W7;
      end
      if (sprite_row[7-b]) begin
        flip[cs[CW-1:0]] = 1'b1;
      end
    end
  end

  assign ram_raddr = row_sel;

  always_comb begin
    row_eff   = row_valid[row_q] ? ram_rdata : '0;
    hit       = |(row_eff & flip_q);
    coll_next = (first_q ? 1'b0 : coll_acc) | hit;
    pix_row   = row_eff;
    pix_row[col_q] = pin_q;
  end

  assign ram_we    = cmd.exec && ((op_q == OP_DRAW) || (op_q == OP_WRITE));
  assign ram_waddr = row_q;
  assign ram_wdata = (op_q == OP_DRAW) ? (row_eff ^ flip_q) : pix_row;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q    <= op;
      row_q   <= row_sel;
      col_q   <= xm[CW-1:0];
      flip_q  <= flip;
      first_q <= (row_offset == 5'd0);
      last_q  <= last_row;
      pin_q   <= pixel_in;
    end
    if (cmd.exec) begin
      pixel_out   <= (op_q == OP_READ) ? row_eff[col_q] : 1'b0;
      collision   <= (op_q == OP_DRAW) ? coll_next : 1'b0;
      sprite_done <= (op_q == OP_DRAW) ? last_q : 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      coll_acc  <= 1'b0;
    end else if (cmd.exec) begin
      unique case (op_q)
        OP_DRAW: begin
          row_valid[row_q] <= 1'b1;
          coll_acc         <= coll_next;
        end
        OP_CLEAR: row_valid <= '0;
        OP_READ:  ;
        OP_WRITE: row_valid[row_q] <= 1'b1;
        default:  ;
      endcase
    end
  end

endmodule

>>> rtl/sprite_xor_frame_buffer_core.sv
// sprite_xor_frame_buffer_core: top level of the sprite xor frame buffer.
// Depends on sxfb_pkg, sxfb_ram, sxfb_ctrl and sxfb_datapath.
//
// An operation word is taken when start is high and busy is low; busy then
// goes high for one cycle, and a new word is taken only once busy is low again.
// The execute cycle is set by the registered read of the frame ram: the row is
// read at the accept edge and the modified row is written back in the execute
// cycle. The result is shown for exactly one cycle with done high, the cycle
// after execute, and the receiver cannot stall it. Clear screen and reset drop
// the per-row valid bits at once, so there is no clearing pass and no wait
// after reset.
module sprite_xor_frame_buffer_core
  import sxfb_pkg::*;
#(
  parameter int WIDTH  = 64,
  parameter int HEIGHT = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] op,
  input  logic [5:0] x,
  input  logic [4:0] y,
  input  logic [7:0] sprite_row,
  input  logic [4:0] row_offset,
  input  logic       last_row,
  input  logic       pixel_in,
  output logic       done,
  output logic       pixel_out,
  output logic       collision,
  output logic       sprite_done
);

  localparam int RW = $clog2(HEIGHT);

  ctrl_cmd_t        cmd;
  logic [RW-1:0]    ram_raddr;
  logic [RW-1:0]    ram_waddr;
  logic [WIDTH-1:0] ram_rdata;
  logic [WIDTH-1:0] ram_wdata;
  logic             ram_we;

  sxfb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  sxfb_datapath #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .op          (op),
    .x           (x),
    .y           (y),
    .sprite_row  (sprite_row),
    .row_offset  (row_offset),
    .last_row    (last_row),
    .pixel_in    (pixel_in),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .pixel_out   (pixel_out),
    .collision   (collision),
    .sprite_done (sprite_done)
  );

  sxfb_ram #(
    .DW    (WIDTH),
    .DEPTH (HEIGHT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_exec_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> (done && !busy))
    else $error("execute cycle not followed by result strobe");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without execute cycle");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> busy)
    else $error("frame write outside execute cycle");

endmodule

>>> tb/sv/sprite_xor_frame_buffer_core_test.sv
`timescale 1ns / 1ps
// sprite_xor_frame_buffer_core_test: self-checking bench for the sprite xor frame buffer,
// a directed table then random sprites, pixel ops and clears; each result checked against a
// predictor or the table's own result. Depends on sxfb_pkg and sprite_xor_frame_buffer_core.
module sprite_xor_frame_buffer_core_test;
  import sxfb_pkg::*;

  localparam int TOTAL_WORDS = 1150;
  localparam int QUIET_FROM  = 1000;
  localparam int STALL_LIMIT = 400;
  localparam int DIR_ROWS    = 22;

  typedef struct packed {
    logic [1:0] op;
    logic [5:0] x;
    logic [4:0] y;
    logic [7:0] spr;
    logic [4:0] roff;
    logic       last;
    logic       pin;
  } op_word_t;

  typedef struct packed {
    logic pixel;
    logic coll;
    logic sdone;
  } frame_result_t;

  typedef struct packed {
    op_word_t      w;
    logic          chk;
    frame_result_t r;
  } dir_row_t;

  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{'{OP_READ,  6'd0,  5'd0,  8'h00, 5'd0,  1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b0}},
    '{'{OP_READ,  6'd63, 5'd31, 8'hff, 5'd31, 1'b1, 1'b1}, 1'b1, '{1'b0, 1'b0, 1'b0}},
    '{'{OP_DRAW,  6'd0,  5'd0,  8'hff, 5'd0,  1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b0}},
    '{'{OP_DRAW,  6'd0,  5'd0,  8'hff, 5'd1,  1'b1, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b1}},
    '{'{OP_READ,  6'd0,  5'd0,  8'h00, 5'd0,  1'b0, 1'b0}, 1'b0, '{1'b0, 1'b0, 1'b0}},
    '{'{OP_DRAW,  6'd0,  5'd0,  8'hff, 5'd0,  1'b1, 1'b1}, 1'b0, '{1'b0, 1'b0, 1'b0}},
    '{'{OP_READ,  6'd7,  5'd0,  8'h00, 5'd0,  1'b0, 1'b0}, 1'b0, '{1'b0, 1'b0, 1'b0}},
    '{'{OP_DRAW,  6'd60, 5'd31, 8'ha5, 5'd0,  1'b0, 1'b0}, 1'b0, '{1'b0, 1'b0, 1'b0}},
    '{'{OP_DRAW,  6'd60, 5'd31, 8'h81, 5'd1,  1'b1, 1'b0}, 1'b0, '{1'b0, 1'b0, 1'b0}},
    '{'{OP_READ,  6'd3,  5'd0,  8'h00, 5'd0,  1'b0, 1'b0}, 1'b0, '{1'b0, 1'b0, 1'b0}},
    '{'{OP_WRITE, 6'd63, 5'd31, 8'h00, 5'd0,  1'b0, 1'b1}, 1'b1, '{1'b0, 1'b0, 1'b0}},
    '{'{OP_READ,  6'd63, 5'd31, 8'h00, 5'd0,  1'b0, 1'b0}, 1'b0, '{1'b0, 1'b0, 1'b0}},
    '{'{OP_WRITE, 6'd63, 5'd31, 8'hff, 5'd31, 1'b1, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b0}},
    '{'{OP_READ,  6'd63, 5'd31, 8'h00, 5'd0,  1'b0, 1'b0}, 1'b0, '{1'b0, 1'b0, 1'b0}},
    '{'{OP_DRAW,  6'd5,  5'd5,  8'h00, 5'd0,  1'b1, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b1}},
    '{'{OP_DRAW,  6'd63, 5'd31, 8'hff, 5'd31, 1'b1, 1'b0}, 1'b0, '{1'b0, 1'b0, 1'b0}},
    '{'{OP_DRAW,  6'd63, 5'd31, 8'hff, 5'd31, 1'b0, 1'b1}, 1'b0, '{1'b0, 1'b0, 1'b0}},
    '{'{OP_CLEAR, 6'd63, 5'd31, 8'hff, 5'd31, 1'b1, 1'b1}, 1'b1, '{1'b0, 1'b0, 1'b0}},
    '{'{OP_READ,  6'd63, 5'd30, 8'h00, 5'd0,  1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b0}},
    '{'{OP_DRAW,  6'd62, 5'd30, 8'h01, 5'd3,  1'b0, 1'b1}, 1'b0, '{1'b0, 1'b0, 1'b0}},
    '{'{OP_READ,  6'd62, 5'd1,  8'hff, 5'd31, 1'b1, 1'b1}, 1'b0, '{1'b0, 1'b0, 1'b0}},
    '{'{OP_DRAW,  6'd1,  5'd1,  8'h80, 5'd0,  1'b1, 1'b0}, 1'b0, '{1'b0, 1'b0, 1'b0}}
  };

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  logic [1:0] op;
  logic [5:0] x;
  logic [4:0] y;
  logic [7:0] sprite_row;
  logic [4:0] row_offset;
  logic       last_row;
  logic       pixel_in;
  logic       done;
  logic       pixel_out;
  logic       collision;
  logic       sprite_done;

  logic [63:0]   frame_px [32];
  logic          sprite_hit;
  frame_result_t awaited_results [$];
  logic          typed_chk;
  frame_result_t typed_res;
  int            errors;
  int            issued;
  int            stall_cnt;
  logic          idle_on;

  sprite_xor_frame_buffer_core uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .op(op),
    .x(x),
    .y(y),
    .sprite_row(sprite_row),
    .row_offset(row_offset),
    .last_row(last_row),
    .pixel_in(pixel_in),
    .done(done),
    .pixel_out(pixel_out),
    .collision(collision),
    .sprite_done(sprite_done)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic frame_result_t apply_frame_op(op_word_t w);
    frame_result_t res;
    logic [63:0]   flip;
    logic [4:0]    r;
    logic [5:0]    c;
    res = '0;
    case (w.op)
      OP_DRAW: begin
        r = w.y + w.roff;
        flip = '0;
        if (w.roff == 5'd0) sprite_hit = 1'b0;
        for (int b = 0; b < 8; b++) begin
          if (w.spr[7 - b]) begin
            c = w.x + 6'(b);
            flip[c] = 1'b1;
          end
        end
        if ((frame_px[r] & flip) != 64'd0) sprite_hit = 1'b1;
        frame_px[r] = frame_px[r] ^ flip;
        res.coll = sprite_hit;
        res.sdone = w.last;
      end
      OP_CLEAR: begin
        for (int i = 0; i < 32; i++) frame_px[i] = '0;
      end
      OP_READ: begin
        res.pixel = frame_px[w.y][w.x];
      end
      default: begin
        frame_px[w.y][w.x] = w.pin;
      end
    endcase
    return res;
  endfunction

  // accept and result monitor
  always @(posedge clk) begin
    frame_result_t exp_res;
    frame_result_t got;
    op_word_t      w;
    if (!rst) begin
      if (done) begin
        got = '{pixel_out, collision, sprite_done};
        if (awaited_results.size() == 0) begin
          $display("%0t: result with no word pending: expected none actual %b", $time, got);
          errors++;
        end else begin
          exp_res = awaited_results.pop_front();
          if (got.pixel !== exp_res.pixel) begin
            $display("%0t: pixel_out expected %b actual %b", $time, exp_res.pixel, got.pixel);
            errors++;
          end
          if (got.coll !== exp_res.coll) begin
            $display("%0t: collision expected %b actual %b", $time, exp_res.coll, got.coll);
            errors++;
          end
          if (got.sdone !== exp_res.sdone) begin
            $display("%0t: sprite_done expected %b actual %b", $time, exp_res.sdone, got.sdone);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        w = '{op, x, y, sprite_row, row_offset, last_row, pixel_in};
        exp_res = apply_frame_op(w);
        awaited_results.push_back(typed_chk ? typed_res : exp_res);
      end
    end
  end

  // watchdog on cycles with no word accepted and no result
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic drive_word(input op_word_t w, input logic chk, input frame_result_t e);
    op = w.op;
    x = w.x;
    y = w.y;
    sprite_row = w.spr;
    row_offset = w.roff;
    last_row = w.last;
    pixel_in = w.pin;
    typed_chk = chk;
    typed_res = e;
    start = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    issued++;
    if (idle_on && issued < QUIET_FROM && $urandom_range(0, 3) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  endtask

  function automatic op_word_t noise_word(logic [1:0] code);
    op_word_t    w;
    logic [31:0] raw;
    raw = $urandom;
    w = raw[27:0];
    w.op = code;
    return w;
  endfunction

  task automatic random_sprite();
    op_word_t w;
    logic [5:0] sx;
    logic [4:0] sy;
    logic [4:0] first;
    int n;
    logic drop_last;
    sx = ($urandom_range(0, 5) == 0) ? ($urandom_range(0, 1) ? 6'd63 : 6'd57) : 6'($urandom);
    sy = ($urandom_range(0, 5) == 0) ? 5'd31 : 5'($urandom);
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 32) : $urandom_range(1, 6);
    first = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(1, 31)) : 5'd0;
    drop_last = ($urandom_range(0, 9) == 0);
    for (int i = 0; i < n; i++) begin
      w = noise_word(OP_DRAW);
      w.x = sx;
      w.y = sy;
      w.roff = first + 5'(i);
      w.last = (i == n - 1) && !drop_last;
      case ($urandom_range(0, 7))
        0: w.spr = 8'h00;
        1: w.spr = 8'hff;
        default: w.spr = 8'($urandom);
      endcase
      drive_word(w, 1'b0, '0);
    end
    repeat ($urandom_range(0, 3)) begin
      w = noise_word($urandom_range(0, 3) == 0 ? OP_WRITE : OP_READ);
      w.x = sx + 6'($urandom_range(0, 7));
      w.y = sy + 5'($urandom_range(0, n - 1));
      drive_word(w, 1'b0, '0);
    end
  endtask

  initial begin
    op_word_t w;
    int blk;
    rst = 1'b1;
    start = 1'b0;
    op = OP_DRAW;
    x = '0;
    y = '0;
    sprite_row = '0;
    row_offset = '0;
    last_row = 1'b0;
    pixel_in = 1'b0;
    typed_chk = 1'b0;
    typed_res = '0;
    errors = 0;
    issued = 0;
    idle_on = 1'b1;
    sprite_hit = 1'b0;
    for (int i = 0; i < 32; i++) frame_px[i] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) drive_word(DIR_TABLE[i].w, DIR_TABLE[i].chk, DIR_TABLE[i].r);

    blk = 0;
    while (issued < TOTAL_WORDS) begin
      case ($urandom_range(0, 39))
        0: drive_word(noise_word(OP_CLEAR), 1'b0, '0);
        1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12: begin
          repeat ($urandom_range(1, 4)) begin
            w = noise_word($urandom_range(0, 1) ? OP_WRITE : OP_READ);
            drive_word(w, 1'b0, '0);
          end
        end
        default: random_sprite();
      endcase
      if (issued / 64 != blk) begin
        blk = issued / 64;
        idle_on = $urandom_range(0, 2) != 0;
      end
    end

    start = 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/sxfb_pkg.sv
rtl/sxfb_ram.sv
rtl/sxfb_ctrl.sv
rtl/sxfb_datapath.sv
rtl/sprite_xor_frame_buffer_core.sv
tb/sv/sprite_xor_frame_buffer_core_test.sv
